FILE: rtl/eulrot_pkg.sv
`default_nettype none
package eulrot_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_WIDTH = 16;
    localparam int FRAC_BITS   = 16;

    // q1.16 sine/cosine, signed, magnitude up to 1.0
    localparam int TRIG_WIDTH  = FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] TRIG_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // series arithmetic in q2.30
    localparam int Q30         = 30;
    localparam int X_WIDTH     = 31;
    localparam int TERM_WIDTH  = 32;
    localparam int ACC_WIDTH   = 35;
    localparam int RECIP_SHIFT = 32;
    localparam int DIV_WIDTH   = 9;
    localparam int TRIG_SHIFT  = Q30 - FRAC_BITS;
    localparam int N_TERMS     = 8;
    localparam logic [X_WIDTH-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [TERM_WIDTH-1:0] ONE_Q30 = TERM_WIDTH'(64'd1 << Q30);

    localparam logic [DIV_WIDTH-1:0] SIN_DIV [N_TERMS] =
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [DIV_WIDTH-1:0] COS_DIV [N_TERMS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};
    localparam logic [RECIP_SHIFT-1:0] SIN_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd272)};
    localparam logic [RECIP_SHIFT-1:0] COS_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd240)};

    localparam int SC_LAT    = 2 + 3 * N_TERMS + 1;
    localparam int ROT_LAT   = 2;
    localparam int TOTAL_LAT = 1 + SC_LAT + 3 * ROT_LAT;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t ray;
        vec3_t cam;
    } vec_pair_t;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

    function automatic coord_t sat_sub(input coord_t a, input coord_t b);
        logic signed [COORD_WIDTH:0] d;
        d = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
        if (d[COORD_WIDTH] == d[COORD_WIDTH-1])
            return d[COORD_WIDTH-1:0];
        else if (d[COORD_WIDTH])
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/eulrot_sincos.sv
`default_nettype none
module eulrot_sincos (
    input  wire logic                                clk,
    input  wire logic [eulrot_pkg::ANGLE_WIDTH-1:0] angle,
    output eulrot_pkg::trig_t                        sin_val,
    output eulrot_pkg::trig_t                        cos_val
);
    localparam int R_W  = eulrot_pkg::ANGLE_WIDTH - 2;
    localparam int XW   = eulrot_pkg::X_WIDTH;
    localparam int TW   = eulrot_pkg::TERM_WIDTH;
    localparam int AW   = eulrot_pkg::ACC_WIDTH;
    localparam int NT   = eulrot_pkg::N_TERMS;
    localparam int RW   = eulrot_pkg::RECIP_SHIFT;
    localparam int DW   = eulrot_pkg::DIV_WIDTH;
    localparam int QLEN = eulrot_pkg::SC_LAT - 1;
    localparam int FB   = eulrot_pkg::FRAC_BITS;
    localparam int SH   = eulrot_pkg::TRIG_SHIFT;

    logic [1:0] quad_reg [QLEN];

    logic [XW-1:0]          x_reg;
    logic [R_W+XW-1:0]      xprod;
    logic [2*XW-1:0]        xsq;
    logic [TW-1:0]          x2_reg;
    logic [TW-1:0]          ts0_reg;
    eulrot_pkg::acc_t       ss0_reg;

    // per term: a = product by x^2, b = reciprocal estimate, c = correction
    logic [TW-1:0]          ts_in [NT];
    logic [TW-1:0]          tc_in [NT];
    eulrot_pkg::acc_t       ss_in [NT];
    eulrot_pkg::acc_t       sc_in [NT];
    logic [TW-1:0]          x2_in [NT];

    logic [TW-1:0]          ns_a [NT];
    logic [TW-1:0]          nc_a [NT];
    eulrot_pkg::acc_t       ss_a [NT];
    eulrot_pkg::acc_t       sc_a [NT];
    logic [TW-1:0]          x2_a [NT];
    logic [TW-1:0]          qs_b [NT];
    logic [TW-1:0]          qc_b [NT];
    logic [TW-1:0]          ns_b [NT];
    logic [TW-1:0]          nc_b [NT];
    eulrot_pkg::acc_t       ss_b [NT];
    eulrot_pkg::acc_t       sc_b [NT];
    logic [TW-1:0]          x2_b [NT];
    logic [TW-1:0]          ts_c [NT];
    logic [TW-1:0]          tc_c [NT];
    eulrot_pkg::acc_t       ss_c [NT];
    eulrot_pkg::acc_t       sc_c [NT];
    logic [TW-1:0]          x2_c [NT];

    assign xprod = (R_W+XW)'(angle[R_W-1:0]) * (R_W+XW)'(eulrot_pkg::HALF_PI_Q30);
    assign xsq   = (2*XW)'(x_reg) * (2*XW)'(x_reg);

    always_ff @(posedge clk)
    begin
        quad_reg[0] <= angle[eulrot_pkg::ANGLE_WIDTH-1 -: 2];
        for (int i = 1; i < QLEN; i++)
            quad_reg[i] <= quad_reg[i-1];
        x_reg   <= xprod[R_W +: XW];
        x2_reg  <= xsq[eulrot_pkg::Q30 +: TW];
        ts0_reg <= TW'(x_reg);
        ss0_reg <= AW'(x_reg);
    end

    for (genvar k = 0; k < NT; k++) begin : g_term
        logic [2*TW-1:0]   ps_prod, pc_prod;
        logic [TW+RW-1:0]  qs_prod, qc_prod;
        logic [TW+DW:0]    rs, rc;
        logic [TW-1:0]     ts_next, tc_next;

        if (k == 0) begin : g_first
            assign ts_in[k] = ts0_reg;
            assign tc_in[k] = eulrot_pkg::ONE_Q30;
            assign ss_in[k] = ss0_reg;
            assign sc_in[k] = AW'(eulrot_pkg::ONE_Q30);
            assign x2_in[k] = x2_reg;
        end else begin : g_next
            assign ts_in[k] = ts_c[k-1];
            assign tc_in[k] = tc_c[k-1];
            assign ss_in[k] = ss_c[k-1];
            assign sc_in[k] = sc_c[k-1];
            assign x2_in[k] = x2_c[k-1];
        end

        assign ps_prod = (2*TW)'(ts_in[k]) * (2*TW)'(x2_in[k]);
        assign pc_prod = (2*TW)'(tc_in[k]) * (2*TW)'(x2_in[k]);
        assign qs_prod = (TW+RW)'(ns_a[k]) * (TW+RW)'(eulrot_pkg::SIN_RECIP[k]);
        assign qc_prod = (TW+RW)'(nc_a[k]) * (TW+RW)'(eulrot_pkg::COS_RECIP[k]);

        // reciprocal estimate is at most one short
        assign rs = (TW+DW+1)'(ns_b[k])
                  - (TW+DW+1)'(qs_b[k]) * (TW+DW+1)'(eulrot_pkg::SIN_DIV[k]);
        assign rc = (TW+DW+1)'(nc_b[k])
                  - (TW+DW+1)'(qc_b[k]) * (TW+DW+1)'(eulrot_pkg::COS_DIV[k]);
        assign ts_next = qs_b[k] + TW'(rs >= (TW+DW+1)'(eulrot_pkg::SIN_DIV[k]));
        assign tc_next = qc_b[k] + TW'(rc >= (TW+DW+1)'(eulrot_pkg::COS_DIV[k]));

        always_ff @(posedge clk)
        begin
            ns_a[k] <= ps_prod[eulrot_pkg::Q30 +: TW];
            nc_a[k] <= pc_prod[eulrot_pkg::Q30 +: TW];
            ss_a[k] <= ss_in[k];
            sc_a[k] <= sc_in[k];
            x2_a[k] <= x2_in[k];

            qs_b[k] <= qs_prod[RW +: TW];
            qc_b[k] <= qc_prod[RW +: TW];
            ns_b[k] <= ns_a[k];
            nc_b[k] <= nc_a[k];
            ss_b[k] <= ss_a[k];
            sc_b[k] <= sc_a[k];
            x2_b[k] <= x2_a[k];

            ts_c[k] <= ts_next;
            tc_c[k] <= tc_next;
            x2_c[k] <= x2_b[k];
            if (k % 2 == 0)
            begin
                ss_c[k] <= ss_b[k] - AW'(ts_next);
                sc_c[k] <= sc_b[k] - AW'(tc_next);
            end
            else
            begin
                ss_c[k] <= ss_b[k] + AW'(ts_next);
                sc_c[k] <= sc_b[k] + AW'(tc_next);
            end
        end
    end

    function automatic logic [FB:0] round_q16(input eulrot_pkg::acc_t v);
        eulrot_pkg::acc_t r;
        r = v + AW'(1 << (SH - 1));
        if (v < 0)
            return '0;
        else if (r[AW-1:SH] > (AW-SH)'(eulrot_pkg::TRIG_ONE))
            return eulrot_pkg::TRIG_ONE;
        else
            return r[SH +: FB+1];
    endfunction

    logic [FB:0]       s16, c16;
    eulrot_pkg::trig_t s_pos, c_pos;
    eulrot_pkg::trig_t sin_next, cos_next;
    eulrot_pkg::trig_t sin_reg, cos_reg;

    assign s16   = round_q16(ss_c[NT-1]);
    assign c16   = round_q16(sc_c[NT-1]);
    assign s_pos = eulrot_pkg::trig_t'({1'b0, s16});
    assign c_pos = eulrot_pkg::trig_t'({1'b0, c16});

    always_comb
    begin
        case (eulrot_pkg::quad_t'(quad_reg[QLEN-1]))
            eulrot_pkg::QUAD_I:
            begin
                sin_next = s_pos;
                cos_next = c_pos;
            end
            eulrot_pkg::QUAD_II:
            begin
                sin_next = c_pos;
                cos_next = -s_pos;
            end
            eulrot_pkg::QUAD_III:
            begin
                sin_next = -s_pos;
                cos_next = -c_pos;
            end
            default:
            begin
                sin_next = -c_pos;
                cos_next = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
`default_nettype wire

FILE: rtl/eulrot_rotate.sv
`default_nettype none
module eulrot_rotate (
    input  wire logic               clk,
    input  wire eulrot_pkg::coord_t p_ray,
    input  wire eulrot_pkg::coord_t q_ray,
    input  wire eulrot_pkg::coord_t p_cam,
    input  wire eulrot_pkg::coord_t q_cam,
    input  wire eulrot_pkg::trig_t  sin_val,
    input  wire eulrot_pkg::trig_t  cos_val,
    output eulrot_pkg::coord_t      p_ray_rot,
    output eulrot_pkg::coord_t      q_ray_rot,
    output eulrot_pkg::coord_t      p_cam_rot,
    output eulrot_pkg::coord_t      q_cam_rot
);
    localparam int CW = eulrot_pkg::COORD_WIDTH;
    localparam int PW = CW + eulrot_pkg::TRIG_WIDTH;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [PW:0]   sum_t;

    // p' = p*c - q*s, q' = p*s + q*c, round half up then saturate
    function automatic eulrot_pkg::coord_t rnd_sat(input sum_t v);
        sum_t t;
        t = (v + sum_t'(1 << (eulrot_pkg::FRAC_BITS - 1))) >>> eulrot_pkg::FRAC_BITS;
        if ((&t[PW:CW-1]) || !(|t[PW:CW-1]))
            return t[CW-1:0];
        else if (t[PW])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    prod_t rpc_reg, rqs_reg, rps_reg, rqc_reg;
    prod_t cpc_reg, cqs_reg, cps_reg, cqc_reg;
    eulrot_pkg::coord_t prr_reg, qrr_reg, pcr_reg, qcr_reg;

    always_ff @(posedge clk)
    begin
        rpc_reg <= p_ray * cos_val;
        rqs_reg <= q_ray * sin_val;
        rps_reg <= p_ray * sin_val;
        rqc_reg <= q_ray * cos_val;
        cpc_reg <= p_cam * cos_val;
        cqs_reg <= q_cam * sin_val;
        cps_reg <= p_cam * sin_val;
        cqc_reg <= q_cam * cos_val;

        prr_reg <= rnd_sat(sum_t'(rpc_reg) - sum_t'(rqs_reg));
        qrr_reg <= rnd_sat(sum_t'(rps_reg) + sum_t'(rqc_reg));
        pcr_reg <= rnd_sat(sum_t'(cpc_reg) - sum_t'(cqs_reg));
        qcr_reg <= rnd_sat(sum_t'(cps_reg) + sum_t'(cqc_reg));
    end

    assign p_ray_rot = prr_reg;
    assign q_ray_rot = qrr_reg;
    assign p_cam_rot = pcr_reg;
    assign q_cam_rot = qcr_reg;

endmodule
`default_nettype wire

FILE: rtl/euler_xyz_vector_rotation.sv
// Rotates a ray direction and the camera offset (camera minus object, saturated) about
// x, then y, then z by three binary angles; coordinates are signed q16.16 and every
// stage saturates. Fully pipelined: one item may be started in every cycle (busy stays
// low) and its result is taken with a one-cycle done strobe, in start order. The
// pipeline runs through an input register and the sine/cosine generator, a 27-stage
// series evaluator (three stages per series term), followed by three two-stage
// rotation units. The receiver cannot stall, so done must be taken when seen.
`default_nettype none
module euler_xyz_vector_rotation (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire eulrot_pkg::coord_t                  ray_x,
    input  wire eulrot_pkg::coord_t                  ray_y,
    input  wire eulrot_pkg::coord_t                  ray_z,
    input  wire eulrot_pkg::coord_t                  cam_pos_x,
    input  wire eulrot_pkg::coord_t                  cam_pos_y,
    input  wire eulrot_pkg::coord_t                  cam_pos_z,
    input  wire eulrot_pkg::coord_t                  obj_pos_x,
    input  wire eulrot_pkg::coord_t                  obj_pos_y,
    input  wire eulrot_pkg::coord_t                  obj_pos_z,
    input  wire logic [eulrot_pkg::ANGLE_WIDTH-1:0] angle_x,
    input  wire logic [eulrot_pkg::ANGLE_WIDTH-1:0] angle_y,
    input  wire logic [eulrot_pkg::ANGLE_WIDTH-1:0] angle_z,
    output      logic                                done,
    output eulrot_pkg::coord_t                       rot_ray_x,
    output eulrot_pkg::coord_t                       rot_ray_y,
    output eulrot_pkg::coord_t                       rot_ray_z,
    output eulrot_pkg::coord_t                       rot_cam_x,
    output eulrot_pkg::coord_t                       rot_cam_y,
    output eulrot_pkg::coord_t                       rot_cam_z
);
    localparam int TL  = eulrot_pkg::TOTAL_LAT;
    localparam int SCL = eulrot_pkg::SC_LAT;
    localparam int RL  = eulrot_pkg::ROT_LAT;
    localparam int AGW = eulrot_pkg::ANGLE_WIDTH;

    logic [TL-1:0] vld_reg;

    eulrot_pkg::vec3_t    ray_reg, cam_reg, obj_reg;
    logic [AGW-1:0]       ax_reg, ay_reg, az_reg;
    eulrot_pkg::vec_pair_t vec_dly [SCL];

    eulrot_pkg::trig_t sx, cx, sy, cy, sz, cz;
    eulrot_pkg::trig_t sy_dly [RL];
    eulrot_pkg::trig_t cy_dly [RL];
    eulrot_pkg::trig_t sz_dly [2*RL];
    eulrot_pkg::trig_t cz_dly [2*RL];

    // coordinates that a stage leaves alone ride alongside it
    eulrot_pkg::coord_t xr_dly [RL];
    eulrot_pkg::coord_t xc_dly [RL];
    eulrot_pkg::coord_t yr_dly [RL];
    eulrot_pkg::coord_t yc_dly [RL];
    eulrot_pkg::coord_t zr_dly [RL];
    eulrot_pkg::coord_t zc_dly [RL];

    eulrot_pkg::coord_t x1_ry, x1_rz, x1_cy, x1_cz;
    eulrot_pkg::coord_t y1_rz, y1_rx, y1_cz, y1_cx;
    eulrot_pkg::coord_t z1_rx, z1_ry, z1_cx, z1_cy;

    eulrot_pkg::vec_pair_t vec_at_rot;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TL-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        ray_reg <= '{x: ray_x, y: ray_y, z: ray_z};
        cam_reg <= '{x: cam_pos_x, y: cam_pos_y, z: cam_pos_z};
        obj_reg <= '{x: obj_pos_x, y: obj_pos_y, z: obj_pos_z};
        ax_reg  <= angle_x;
        ay_reg  <= angle_y;
        az_reg  <= angle_z;

        vec_dly[0].ray   <= ray_reg;
        vec_dly[0].cam.x <= eulrot_pkg::sat_sub(cam_reg.x, obj_reg.x);
        vec_dly[0].cam.y <= eulrot_pkg::sat_sub(cam_reg.y, obj_reg.y);
        vec_dly[0].cam.z <= eulrot_pkg::sat_sub(cam_reg.z, obj_reg.z);
        for (int i = 1; i < SCL; i++)
            vec_dly[i] <= vec_dly[i-1];

        sy_dly[0] <= sy;
        cy_dly[0] <= cy;
        for (int i = 1; i < RL; i++)
        begin
            sy_dly[i] <= sy_dly[i-1];
            cy_dly[i] <= cy_dly[i-1];
        end
        sz_dly[0] <= sz;
        cz_dly[0] <= cz;
        for (int i = 1; i < 2*RL; i++)
        begin
            sz_dly[i] <= sz_dly[i-1];
            cz_dly[i] <= cz_dly[i-1];
        end

        xr_dly[0] <= vec_at_rot.ray.x;
        xc_dly[0] <= vec_at_rot.cam.x;
        yr_dly[0] <= x1_ry;
        yc_dly[0] <= x1_cy;
        zr_dly[0] <= y1_rz;
        zc_dly[0] <= y1_cz;
        for (int i = 1; i < RL; i++)
        begin
            xr_dly[i] <= xr_dly[i-1];
            xc_dly[i] <= xc_dly[i-1];
            yr_dly[i] <= yr_dly[i-1];
            yc_dly[i] <= yc_dly[i-1];
            zr_dly[i] <= zr_dly[i-1];
            zc_dly[i] <= zc_dly[i-1];
        end
    end

    assign vec_at_rot = vec_dly[SCL-1];

    eulrot_sincos u_sc_x (.clk(clk), .angle(ax_reg), .sin_val(sx), .cos_val(cx));
    eulrot_sincos u_sc_y (.clk(clk), .angle(ay_reg), .sin_val(sy), .cos_val(cy));
    eulrot_sincos u_sc_z (.clk(clk), .angle(az_reg), .sin_val(sz), .cos_val(cz));

    eulrot_rotate u_rot_x (
        .clk      (clk),
        .p_ray    (vec_at_rot.ray.y),
        .q_ray    (vec_at_rot.ray.z),
        .p_cam    (vec_at_rot.cam.y),
        .q_cam    (vec_at_rot.cam.z),
        .sin_val  (sx),
        .cos_val  (cx),
        .p_ray_rot(x1_ry),
        .q_ray_rot(x1_rz),
        .p_cam_rot(x1_cy),
        .q_cam_rot(x1_cz)
    );

    eulrot_rotate u_rot_y (
        .clk      (clk),
        .p_ray    (x1_rz),
        .q_ray    (xr_dly[RL-1]),
        .p_cam    (x1_cz),
        .q_cam    (xc_dly[RL-1]),
        .sin_val  (sy_dly[RL-1]),
        .cos_val  (cy_dly[RL-1]),
        .p_ray_rot(y1_rz),
        .q_ray_rot(y1_rx),
        .p_cam_rot(y1_cz),
        .q_cam_rot(y1_cx)
    );

    eulrot_rotate u_rot_z (
        .clk      (clk),
        .p_ray    (y1_rx),
        .q_ray    (yr_dly[RL-1]),
        .p_cam    (y1_cx),
        .q_cam    (yc_dly[RL-1]),
        .sin_val  (sz_dly[2*RL-1]),
        .cos_val  (cz_dly[2*RL-1]),
        .p_ray_rot(z1_rx),
        .q_ray_rot(z1_ry),
        .p_cam_rot(z1_cx),
        .q_cam_rot(z1_cy)
    );

    assign done      = vld_reg[TL-1];
    assign rot_ray_x = z1_rx;
    assign rot_ray_y = z1_ry;
    assign rot_ray_z = zr_dly[RL-1];
    assign rot_cam_x = z1_cx;
    assign rot_cam_y = z1_cy;
    assign rot_cam_z = zc_dly[RL-1];

    ap_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TL))
        else $error("result strobe without a matching start transfer");

    ap_zero_angle_ray: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(angle_x == '0 && angle_y == '0 && angle_z == '0, TL)
        |-> rot_ray_x == $past(ray_x, TL) && rot_ray_y == $past(ray_y, TL)
            && rot_ray_z == $past(ray_z, TL))
        else $error("zero angles changed the ray");

    ap_zero_angle_cam: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(angle_x == '0 && angle_y == '0 && angle_z == '0, TL)
        |-> rot_cam_x == $past(eulrot_pkg::sat_sub(cam_pos_x, obj_pos_x), TL)
            && rot_cam_z == $past(eulrot_pkg::sat_sub(cam_pos_z, obj_pos_z), TL))
        else $error("zero angles changed the camera offset");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    typedef eulrot_pkg::coord_t coord_t;

    localparam int ANGLE_WIDTH  = eulrot_pkg::ANGLE_WIDTH;
    localparam int TOTAL_LAT    = eulrot_pkg::TOTAL_LAT;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_RANDOM     = 1130;

    typedef struct {
        coord_t ray_x, ray_y, ray_z, cam_x, cam_y, cam_z;
    } rot_result_t;

    // expected rotated vectors, oldest first
    class rotation_scoreboard;
        rot_result_t pending[$];
        int errors;

        function void report(string what, coord_t got, coord_t want);
            errors++;
            if (errors <= 50)
                $display("mismatch %s: got %h expected %h", what, got, want);
        endfunction

        function void note_transfer(rot_result_t r);
            pending.push_back(r);
        endfunction

        function void check_result(rot_result_t got);
            rot_result_t w;
            if (pending.size() == 0)
            begin
                report("result with nothing outstanding", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.ray_x !== w.ray_x) report("rot_ray_x", got.ray_x, w.ray_x);
            if (got.ray_y !== w.ray_y) report("rot_ray_y", got.ray_y, w.ray_y);
            if (got.ray_z !== w.ray_z) report("rot_ray_z", got.ray_z, w.ray_z);
            if (got.cam_x !== w.cam_x) report("rot_cam_x", got.cam_x, w.cam_x);
            if (got.cam_y !== w.cam_y) report("rot_cam_y", got.cam_y, w.cam_y);
            if (got.cam_z !== w.cam_z) report("rot_cam_z", got.cam_z, w.cam_z);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done;
    coord_t ray_x = 0, ray_y = 0, ray_z = 0;
    coord_t cam_pos_x = 0, cam_pos_y = 0, cam_pos_z = 0;
    coord_t obj_pos_x = 0, obj_pos_y = 0, obj_pos_z = 0;
    logic [ANGLE_WIDTH-1:0] angle_x = 0, angle_y = 0, angle_z = 0;
    coord_t rot_ray_x, rot_ray_y, rot_ray_z, rot_cam_x, rot_cam_y, rot_cam_z;

    rotation_scoreboard sb = new();
    longint cycles = 0;

    euler_xyz_vector_rotation DUT (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void sin_cos_q16(logic [ANGLE_WIDTH-1:0] ang,
                                        output longint sn, output longint cs);
        logic [1:0] quad;
        longint unsigned r, x, x2, ts, tc;
        longint ss, sc, s16, c16;
        quad = ang[ANGLE_WIDTH-1 -: 2];
        r = ang[ANGLE_WIDTH-3:0];
        x = (r * 64'd1686629713) >> (ANGLE_WIDTH - 2);
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = x;
        sc = tc;
        for (int k = 1; k <= 8; k++)
        begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                ss -= ts;
                sc -= tc;
            end
            else
            begin
                ss += ts;
                sc += tc;
            end
        end
        s16 = ss < 0 ? 0 : (ss + 8192) >>> 14;
        c16 = sc < 0 ? 0 : (sc + 8192) >>> 14;
        if (s16 > 65536) s16 = 65536;
        if (c16 > 65536) c16 = 65536;
        case (eulrot_pkg::quad_t'(quad))
            eulrot_pkg::QUAD_I:   begin sn = s16;  cs = c16;  end
            eulrot_pkg::QUAD_II:  begin sn = c16;  cs = -s16; end
            eulrot_pkg::QUAD_III: begin sn = -s16; cs = -c16; end
            default:              begin sn = -c16; cs = s16;  end
        endcase
    endfunction

    // 32-bit operands and q1.16 factors fit in 64 bits, so plain products are exact
    function automatic longint weighted_sum(longint a, longint ka, longint b, longint kb);
        return sat32((a * ka + b * kb + 32768) >>> 16);
    endfunction

    function automatic void turn_pair(inout longint p, inout longint q,
                                      input logic [ANGLE_WIDTH-1:0] ang);
        longint s, c, np;
        if (ang == 0) return;
        sin_cos_q16(ang, s, c);
        np = weighted_sum(p, c, q, -s);
        q = weighted_sum(p, s, q, c);
        p = np;
    endfunction

    function automatic void rotate_xyz(inout longint v[3], input logic [ANGLE_WIDTH-1:0] ax,
                                       input logic [ANGLE_WIDTH-1:0] ay,
                                       input logic [ANGLE_WIDTH-1:0] az);
        turn_pair(v[1], v[2], ax);
        turn_pair(v[2], v[0], ay);
        turn_pair(v[0], v[1], az);
    endfunction

    function automatic rot_result_t predict_rotation();
        longint r[3], c[3];
        rot_result_t res;
        r = '{ray_x, ray_y, ray_z};
        c[0] = sat32(longint'(cam_pos_x) - longint'(obj_pos_x));
        c[1] = sat32(longint'(cam_pos_y) - longint'(obj_pos_y));
        c[2] = sat32(longint'(cam_pos_z) - longint'(obj_pos_z));
        rotate_xyz(r, angle_x, angle_y, angle_z);
        rotate_xyz(c, angle_x, angle_y, angle_z);
        res.ray_x = coord_t'(r[0]); res.ray_y = coord_t'(r[1]); res.ray_z = coord_t'(r[2]);
        res.cam_x = coord_t'(c[0]); res.cam_y = coord_t'(c[1]); res.cam_z = coord_t'(c[2]);
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && start && !busy)
            sb.note_transfer(predict_rotation());
        if (rst_n && done)
            sb.check_result('{rot_ray_x, rot_ray_y, rot_ray_z,
                              rot_cam_x, rot_cam_y, rot_cam_z});
        if (cycles > LIMIT_CYCLES)
        begin
            $display("euler_xyz_vector_rotation verification failed");
            $finish;
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return coord_t'($urandom_range(0, 4) << 16) * ($urandom_range(0, 1) ? 1 : -1);
            3, 4: return coord_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ANGLE_WIDTH'($urandom_range(0, 3)) << (ANGLE_WIDTH - 2);
            2: return 16'hffff;
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    // one start transfer; start stays high if the next call follows at once
    task automatic send_item(coord_t rx, coord_t ry, coord_t rz, coord_t cx, coord_t cy,
                             coord_t cz, coord_t ox, coord_t oy, coord_t oz,
                             logic [ANGLE_WIDTH-1:0] ax, logic [ANGLE_WIDTH-1:0] ay,
                             logic [ANGLE_WIDTH-1:0] az);
        start <= 1;
        ray_x <= rx; ray_y <= ry; ray_z <= rz;
        cam_pos_x <= cx; cam_pos_y <= cy; cam_pos_z <= cz;
        obj_pos_x <= ox; obj_pos_y <= oy; obj_pos_z <= oz;
        angle_x <= ax; angle_y <= ay; angle_z <= az;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_random();
        send_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  pick_angle(), pick_angle(), pick_angle());
    endtask

    task automatic pause(int n);
        start <= 0;
        repeat (n) @(posedge clk);
    endtask

    localparam coord_t CMAX = 32'sh7fffffff;
    localparam coord_t CMIN = 32'sh80000000;
    localparam coord_t ONE  = 32'sh00010000;

    initial
    begin
        int burst;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // no rotation, identity path
        send_item(ONE, -ONE, 3, 5, 6, 7, 1, 2, 3, 0, 0, 0);
        // offset saturation both ways
        send_item(CMAX, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0, 0);
        send_item(CMIN, CMAX, -1, CMIN, CMAX, CMAX, ONE, -ONE, CMIN, 0, 0, 0);
        // quadrant boundaries on each axis
        for (int q = 1; q < 4; q++)
        begin
            send_item(ONE, ONE * 2, -ONE, ONE, 0, 0, 0, ONE, 0,
                      ANGLE_WIDTH'(q << 14), 0, 0);
            send_item(ONE, ONE * 2, -ONE, ONE, 0, 0, 0, ONE, 0,
                      0, ANGLE_WIDTH'(q << 14), 0);
            send_item(ONE, ONE * 2, -ONE, ONE, 0, 0, 0, ONE, 0,
                      0, 0, ANGLE_WIDTH'(q << 14));
        end
        // stage saturation at odd multiples of 45 degrees
        send_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                  16'h2000, 16'h2000, 16'h2000);
        send_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                  16'he000, 16'h6000, 16'ha000);
        send_item(-1, -1, -1, -1, -1, -1, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
        send_item(1, 1, 1, 1, 1, 1, 0, 0, 0, 16'h0001, 16'h0001, 16'h0001);
        send_item(32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, 32'shaaaaaaaa,
                  32'sh55555555, 0, 0, 0, 0, 16'h5555, 16'haaaa, 16'h3fff);
        pause(2);
        for (int i = 0; i < N_RANDOM;)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && i < N_RANDOM; j++, i++)
                send_random();
            if (i > N_RANDOM / 2 && i - burst <= N_RANDOM / 2)
            begin
                start <= 0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            else if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 12));
        end
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("euler_xyz_vector_rotation verification clean");
        else
            $display("euler_xyz_vector_rotation verification failed");
        $finish;
    end
endmodule
`default_nettype wire
